// ----- design/nrmc_pkg.sv -----
package nrmc_pkg;

    // Default number of fraction digits kept for a coordinate.
    localparam int FRACTION_DIGITS_DEF = 5;

    // Field and result widths.
    localparam int WHOLE_W = 17;
    localparam int COORD_W = 31;
    localparam int LAT_W   = 30;
    localparam int LON_W   = 31;
    localparam int CHAR_W  = 8;

    // Saturation and clamp limits.
    localparam logic [WHOLE_W-1:0] WHOLE_MAX = 17'd131071;
    localparam logic [COORD_W-1:0] LAT_MAX   = 31'd900000000;
    localparam logic [COORD_W-1:0] LON_MAX   = 31'd1800000000;

    // One degree in output units.
    localparam logic [23:0] E7 = 24'd10000000;

    // Reciprocals for division by 100 (shift 24) and by 15 (shift 32).
    localparam logic [17:0] M100 = 18'd167772;
    localparam logic [31:0] M15  = 32'h1111_1111;

    // ASCII characters the parser looks for.
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C      = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
    localparam logic [CHAR_W-1:0] CH_M      = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h52;

    // Field numbers within a sentence.
    localparam logic [3:0] FLD_PREFIX  = 4'd0;
    localparam logic [3:0] FLD_STATUS  = 4'd2;
    localparam logic [3:0] FLD_LAT     = 4'd3;
    localparam logic [3:0] FLD_LAT_DIR = 4'd4;
    localparam logic [3:0] FLD_LON     = 4'd5;
    localparam logic [3:0] FLD_LON_DIR = 4'd6;
    localparam logic [3:0] FLD_LAST    = 4'd15;

    // Prefix matcher positions: which character is expected next.
    localparam logic [2:0] PFX_IDLE   = 3'd0;
    localparam logic [2:0] PFX_G      = 3'd1;
    localparam logic [2:0] PFX_TALKER = 3'd2;
    localparam logic [2:0] PFX_R      = 3'd3;
    localparam logic [2:0] PFX_M      = 3'd4;
    localparam logic [2:0] PFX_C      = 3'd5;
    localparam logic [2:0] PFX_DONE   = 3'd6;
    localparam logic [2:0] PFX_FAIL   = 3'd7;

    // Updates to the stored fix that one received byte causes.
    typedef struct packed {
        logic              wr_valid;
        logic              valid_val;
        logic              wr_lat;
        logic              wr_lon;
        logic              wr_latdir;
        logic              wr_londir;
        logic [CHAR_W-1:0] dir_val;
        logic              emit;
        logic              clear_valid;
    } t_event;

    // Powers of ten up to one million.
    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- design/nrmc_parse.sv -----
module nrmc_parse
    import nrmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [CHAR_W-1:0]                        i_rx_byte,
    output logic                                     o_ev_valid,
    input  logic                                     i_ev_ready,
    output t_event                                   o_ev,
    output logic [WHOLE_W-1:0]                       o_whole,
    output logic [$clog2(10**FRACTION_DIGITS)-1:0]   o_frac,
    output logic [2:0]                               o_frac_cnt
);

    localparam int FW  = $clog2(10**FRACTION_DIGITS);
    localparam int FXW = FW + 4;

    // Input register.
    logic              r_byte_v;
    logic [CHAR_W-1:0] r_byte;

    // Sentence state.
    logic [3:0]         r_field, n_field;
    logic [2:0]         r_pos, n_pos;
    logic               r_matched, n_matched;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [FW-1:0]      r_frac, n_frac;
    logic [2:0]         r_cnt, n_cnt;
    logic [2:0]         r_flags, n_flags;

    // Event register toward the converter.
    logic               r_ev_valid;
    t_event             r_ev;
    logic [WHOLE_W-1:0] r_ev_whole;
    logic [FW-1:0]      r_ev_frac;
    logic [2:0]         r_ev_cnt;

    logic               en_ev;
    logic               fire;
    logic               first;
    logic               is_digit;
    logic [3:0]         digit;
    logic [20:0]        whole_next;
    logic [FXW-1:0]     frac_next;
    logic               pfx_ok;
    logic               end_matched;
    t_event             end_ev;
    t_event             ev;
    logic               ev_any;

    // The byte register moves on when the event register is free or draining.
    assign en_ev   = !r_ev_valid || i_ev_ready;
    assign fire    = r_byte_v && en_ev;
    assign o_ready = !r_byte_v || en_ev;

    // Character classes and digit accumulation.
    assign first      = !r_flags[0];
    assign is_digit   = r_byte inside {[CH_0:CH_9]};
    assign digit      = 4'(r_byte - CH_0);
    assign whole_next = 21'(r_whole) * 21'd10 + 21'(digit);
    assign frac_next  = FXW'(r_frac) * FXW'(10) + FXW'(digit);

    assign pfx_ok = (r_pos == PFX_G && r_byte == CH_G) ||
                    (r_pos == PFX_TALKER && (r_byte == CH_P || r_byte == CH_N)) ||
                    (r_pos == PFX_R && r_byte == CH_R) ||
                    (r_pos == PFX_M && r_byte == CH_M) ||
                    (r_pos == PFX_C && r_byte == CH_C);

    // What closing the current field commits to the stored fix.
    always_comb begin
        end_ev      = '0;
        end_matched = (r_field == FLD_PREFIX) ? (r_pos == PFX_DONE) : r_matched;
        if (r_field != FLD_PREFIX && r_matched) begin
            case (r_field)
                FLD_STATUS: begin
                    end_ev.wr_valid  = 1'b1;
                    end_ev.valid_val = r_flags[1];
                end
                FLD_LAT:     end_ev.wr_lat    = r_flags[0];
                FLD_LAT_DIR: end_ev.wr_latdir = !r_flags[0];
                FLD_LON:     end_ev.wr_lon    = r_flags[0];
                FLD_LON_DIR: end_ev.wr_londir = !r_flags[0];
                default: ;
            endcase
        end
    end

    // Per-byte sentence parsing.
    always_comb begin
        n_field   = r_field;
        n_pos     = r_pos;
        n_matched = r_matched;
        n_whole   = r_whole;
        n_frac    = r_frac;
        n_cnt     = r_cnt;
        n_flags   = r_flags;
        ev        = '0;
        case (r_byte)
            CH_DOLLAR: begin
                n_field   = FLD_PREFIX;
                n_pos     = PFX_G;
                n_matched = 1'b0;
                n_whole   = '0;
                n_frac    = '0;
                n_cnt     = '0;
                n_flags   = '0;
            end
            CH_COMMA: begin
                ev        = end_ev;
                n_matched = end_matched;
                if (r_field != FLD_LAST) begin
                    n_field = r_field + 4'd1;
                end
                n_whole = '0;
                n_frac  = '0;
                n_cnt   = '0;
                n_flags = '0;
            end
            CH_NL: begin
                ev             = end_ev;
                ev.emit        = 1'b1;
                ev.clear_valid = !end_matched;
                n_field        = FLD_PREFIX;
                n_pos          = PFX_IDLE;
                n_matched      = 1'b0;
                n_whole        = '0;
                n_frac         = '0;
                n_cnt          = '0;
                n_flags        = '0;
            end
            default: begin
                case (r_field)
                    FLD_PREFIX: n_pos = pfx_ok ? r_pos + 3'd1 : PFX_FAIL;
                    FLD_STATUS: begin
                        if (first && r_byte == CH_A) begin
                            n_flags[1] = 1'b1;
                        end
                        n_flags[0] = 1'b1;
                    end
                    FLD_LAT, FLD_LON: begin
                        // Numbers stop at the first character that is not part of one.
                        if (!r_flags[2]) begin
                            n_flags[0] = 1'b1;
                            if (is_digit) begin
                                if (!r_flags[1]) begin
                                    n_whole = (whole_next > 21'(WHOLE_MAX)) ?
                                              WHOLE_MAX : whole_next[WHOLE_W-1:0];
                                end else if (r_cnt < 3'(FRACTION_DIGITS)) begin
                                    n_frac = frac_next[FW-1:0];
                                    n_cnt  = r_cnt + 3'd1;
                                end
                            end else if (r_byte == CH_DOT && !r_flags[1]) begin
                                n_flags[1] = 1'b1;
                            end else begin
                                n_flags[2] = 1'b1;
                            end
                        end
                    end
                    FLD_LAT_DIR: begin
                        if (first && r_matched) begin
                            ev.wr_latdir = 1'b1;
                            ev.dir_val   = r_byte;
                        end
                        n_flags[0] = 1'b1;
                    end
                    FLD_LON_DIR: begin
                        if (first && r_matched) begin
                            ev.wr_londir = 1'b1;
                            ev.dir_val   = r_byte;
                        end
                        n_flags[0] = 1'b1;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign ev_any = ev.wr_valid || ev.wr_lat || ev.wr_lon || ev.wr_latdir ||
                    ev.wr_londir || ev.emit || ev.clear_valid;

    // Control and sentence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_v   <= 1'b0;
            r_ev_valid <= 1'b0;
            r_field    <= '0;
            r_pos      <= PFX_IDLE;
            r_matched  <= 1'b0;
            r_whole    <= '0;
            r_frac     <= '0;
            r_cnt      <= '0;
            r_flags    <= '0;
        end else begin
            if (o_ready) begin
                r_byte_v <= i_valid;
            end
            if (en_ev) begin
                r_ev_valid <= fire && ev_any;
            end
            if (fire) begin
                r_field   <= n_field;
                r_pos     <= n_pos;
                r_matched <= n_matched;
                r_whole   <= n_whole;
                r_frac    <= n_frac;
                r_cnt     <= n_cnt;
                r_flags   <= n_flags;
            end
        end
    end

    // Payload registers; accumulators are taken before this byte clears them.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_byte <= i_rx_byte;
        end
        if (en_ev) begin
            r_ev       <= ev;
            r_ev_whole <= r_whole;
            r_ev_frac  <= r_frac;
            r_ev_cnt   <= r_cnt;
        end
    end

    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;
    assign o_whole    = r_ev_whole;
    assign o_frac     = r_ev_frac;
    assign o_frac_cnt = r_ev_cnt;

endmodule

// ----- design/nrmc_conv.sv -----
module nrmc_conv
    import nrmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  t_event                                   i_ev,
    input  logic [WHOLE_W-1:0]                       i_whole,
    input  logic [$clog2(10**FRACTION_DIGITS)-1:0]   i_frac,
    input  logic [2:0]                               i_frac_cnt,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output t_event                                   o_ev,
    output logic [COORD_W-1:0]                       o_coord
);

    localparam int FW     = $clog2(10**FRACTION_DIGITS);
    localparam int PW     = FW + 20;
    localparam int STAGES = 5;

    // Stage valids and carried events.
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] en;
    t_event            r_ev [STAGES];

    // Stage payloads.
    logic [WHOLE_W-1:0] r_w1;
    logic [10:0]        r_q1;
    logic [FW-1:0]      r_fs1;
    logic [10:0]        r_deg2;
    logic [6:0]         r_min2;
    logic [FW-1:0]      r_fs2;
    logic [29:0]        r_x3;
    logic [33:0]        r_degs3;
    logic [27:0]        r_y4;
    logic [23:0]        r_q4;
    logic [33:0]        r_degs4;
    logic [COORD_W-1:0] r_coord5;

    logic [34:0]        prod100;
    logic [PW-1:0]      frac_prod;
    logic [WHOLE_W-1:0] rem100;
    logic [29:0]        x_sum;
    logic [33:0]        degs;
    logic [59:0]        prod15;
    logic [27:0]        rem15;
    logic [23:0]        q15;
    logic [33:0]        v_sum;
    logic [COORD_W-1:0] limit;

    // A stage loads when it is empty or its successor moves.
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end
    assign o_ready = en[0];

    // Stage 1: whole part over 100 by reciprocal, fraction to full scale.
    assign prod100   = 35'(i_whole) * 35'(M100);
    assign frac_prod = PW'(i_frac) *
                       PW'(pow10(3'(FRACTION_DIGITS) - i_frac_cnt));

    // Stage 2: quotient correction gives degrees and whole minutes.
    assign rem100 = r_w1 - WHOLE_W'(WHOLE_W'(r_q1) * WHOLE_W'(100));

    // Stage 3: minutes times 1e7 and degrees times 1e7.
    assign x_sum = 30'(r_min2) * 30'(E7) +
                   30'(r_fs2) * 30'(pow10(3'(7 - FRACTION_DIGITS)));
    assign degs  = 34'(r_deg2) * 34'(E7);

    // Stage 4: divide by 60 as a shift by 2 and a reciprocal of 15.
    assign prod15 = 60'(r_x3[29:2]) * 60'(M15);

    // Stage 5: quotient correction, sum and clamp.
    assign rem15 = r_y4 - 28'(28'(r_q4) * 28'd15);
    assign q15   = (rem15 >= 28'd15) ? r_q4 + 24'd1 : r_q4;
    assign v_sum = r_degs4 + 34'(q15);
    assign limit = r_ev[3].wr_lat ? LAT_MAX : LON_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int s = 1; s < STAGES; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ev[0] <= i_ev;
            r_w1    <= i_whole;
            r_q1    <= prod100[34:24];
            r_fs1   <= frac_prod[FW-1:0];
        end
        if (en[1]) begin
            r_ev[1] <= r_ev[0];
            r_fs2   <= r_fs1;
            if (rem100 >= WHOLE_W'(100)) begin
                r_deg2 <= r_q1 + 11'd1;
                r_min2 <= 7'(rem100 - WHOLE_W'(100));
            end else begin
                r_deg2 <= r_q1;
                r_min2 <= 7'(rem100);
            end
        end
        if (en[2]) begin
            r_ev[2] <= r_ev[1];
            r_x3    <= x_sum;
            r_degs3 <= degs;
        end
        if (en[3]) begin
            r_ev[3] <= r_ev[2];
            r_y4    <= r_x3[29:2];
            r_q4    <= prod15[55:32];
            r_degs4 <= r_degs3;
        end
        if (en[4]) begin
            r_ev[4]  <= r_ev[3];
            r_coord5 <= (v_sum > 34'(limit)) ? limit : v_sum[COORD_W-1:0];
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_ev    = r_ev[STAGES-1];
    assign o_coord = r_coord5;

endmodule

// ----- design/nrmc_commit.sv -----
module nrmc_commit
    import nrmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ev_valid,
    output logic               o_ev_ready,
    input  t_event             i_ev,
    input  logic [COORD_W-1:0] i_coord,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_fix_valid,
    output logic [LAT_W-1:0]   o_latitude_e7,
    output logic [CHAR_W-1:0]  o_lat_hemisphere,
    output logic [LON_W-1:0]   o_longitude_e7,
    output logic [CHAR_W-1:0]  o_lon_hemisphere
);

    // Stored fix.
    logic              r_valid, n_valid;
    logic [LAT_W-1:0]  r_lat, n_lat;
    logic [LON_W-1:0]  r_lon, n_lon;
    logic [CHAR_W-1:0] r_latdir, n_latdir;
    logic [CHAR_W-1:0] r_londir, n_londir;

    // Result register.
    logic              r_out_valid;
    logic              r_out_fix;
    logic [LAT_W-1:0]  r_out_lat;
    logic [CHAR_W-1:0] r_out_latdir;
    logic [LON_W-1:0]  r_out_lon;
    logic [CHAR_W-1:0] r_out_londir;

    logic              accept;

    assign o_ev_ready = !r_out_valid || i_ready;
    assign accept     = i_ev_valid && o_ev_ready;

    // Apply this request's updates; a failed prefix clears the status last.
    always_comb begin
        n_valid  = i_ev.wr_valid ? i_ev.valid_val : r_valid;
        if (i_ev.clear_valid) begin
            n_valid = 1'b0;
        end
        n_lat    = i_ev.wr_lat    ? i_coord[LAT_W-1:0] : r_lat;
        n_lon    = i_ev.wr_lon    ? i_coord[LON_W-1:0] : r_lon;
        n_latdir = i_ev.wr_latdir ? i_ev.dir_val       : r_latdir;
        n_londir = i_ev.wr_londir ? i_ev.dir_val       : r_londir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_lat       <= '0;
            r_lon       <= '0;
            r_latdir    <= '0;
            r_londir    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid  <= n_valid;
                r_lat    <= n_lat;
                r_lon    <= n_lon;
                r_latdir <= n_latdir;
                r_londir <= n_londir;
            end
            if (accept && i_ev.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is a snapshot of the fix after this request's updates.
    always_ff @(posedge i_clk) begin
        if (accept && i_ev.emit) begin
            r_out_fix    <= n_valid;
            r_out_lat    <= n_lat;
            r_out_latdir <= n_latdir;
            r_out_lon    <= n_lon;
            r_out_londir <= n_londir;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fix_valid      = r_out_fix;
    assign o_latitude_e7    = r_out_lat;
    assign o_lat_hemisphere = r_out_latdir;
    assign o_longitude_e7   = r_out_lon;
    assign o_lon_hemisphere = r_out_londir;

endmodule

// ----- design/nmea_rmc_position_parser_core.sv -----
// NMEA 0183 RMC position parser. Feed received sentence bytes one request at a time on
// i_rx_byte; one byte is accepted per clock cycle when the output side keeps up. A '$'
// starts a sentence, commas count fields (empty ones included), and only $GPRMC and
// $GNRMC sentences update the stored fix. Every '\n' produces one result carrying the
// stored fix: the status flag ('A' seen and prefix matched), latitude and longitude
// magnitudes in units of 1e-7 degree (clamped at 90 and 180 degrees, fraction digits
// past FRACTION_DIGITS truncated) and the first character of each hemisphere field.
// A byte passes through the input register and the parser's event register, then a
// five-stage divide-by-constant pipeline turns ddmm.mmmm into degrees. Bytes that
// change no stored value leave no work in that pipeline. Only when a finished result
// is held waiting on i_ready and the pipeline behind it has filled does the block stop
// taking bytes.
module nmea_rmc_position_parser_core
    import nrmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_fix_valid,
    output logic [LAT_W-1:0]  o_latitude_e7,
    output logic [CHAR_W-1:0] o_lat_hemisphere,
    output logic [LON_W-1:0]  o_longitude_e7,
    output logic [CHAR_W-1:0] o_lon_hemisphere
);

    localparam int FW = $clog2(10**FRACTION_DIGITS);

    logic               prs_valid;
    logic               prs_ready;
    t_event             prs_ev;
    logic [WHOLE_W-1:0] prs_whole;
    logic [FW-1:0]      prs_frac;
    logic [2:0]         prs_cnt;

    logic               cnv_valid;
    logic               cnv_ready;
    t_event             cnv_ev;
    logic [COORD_W-1:0] cnv_coord;

    // Sentence parser: field counting, prefix check and number accumulation.
    nrmc_parse #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .o_ev_valid (prs_valid),
        .i_ev_ready (prs_ready),
        .o_ev       (prs_ev),
        .o_whole    (prs_whole),
        .o_frac     (prs_frac),
        .o_frac_cnt (prs_cnt)
    );

    // Coordinate conversion to 1e-7 degree.
    nrmc_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (prs_valid),
        .o_ready    (prs_ready),
        .i_ev       (prs_ev),
        .i_whole    (prs_whole),
        .i_frac     (prs_frac),
        .i_frac_cnt (prs_cnt),
        .o_valid    (cnv_valid),
        .i_ready    (cnv_ready),
        .o_ev       (cnv_ev),
        .o_coord    (cnv_coord)
    );

    // Stored fix and result register.
    nrmc_commit u_commit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ev_valid       (cnv_valid),
        .o_ev_ready       (cnv_ready),
        .i_ev             (cnv_ev),
        .i_coord          (cnv_coord),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_fix_valid      (o_fix_valid),
        .o_latitude_e7    (o_latitude_e7),
        .o_lat_hemisphere (o_lat_hemisphere),
        .o_longitude_e7   (o_longitude_e7),
        .o_lon_hemisphere (o_lon_hemisphere)
    );

endmodule

// ----- design/nrmc_checker.sv -----
module nrmc_checker
    import nrmc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_fix_valid,
    input logic [LAT_W-1:0]  o_latitude_e7,
    input logic [CHAR_W-1:0] o_lat_hemisphere,
    input logic [LON_W-1:0]  o_longitude_e7,
    input logic [CHAR_W-1:0] o_lon_hemisphere
);

    // A result that is not taken stays, unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fix_valid) &&
        $stable(o_latitude_e7) && $stable(o_lat_hemisphere) &&
        $stable(o_longitude_e7) && $stable(o_lon_hemisphere))
        else $error("result changed while stalled");

    // Latitude never exceeds 90 degrees.
    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_latitude_e7 <= LAT_W'(LAT_MAX))
        else $error("latitude above clamp");

    // Longitude never exceeds 180 degrees.
    a_lon_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_longitude_e7 <= LON_MAX)
        else $error("longitude above clamp");

    // Reset empties the result register and opens the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not empty after reset");

endmodule

bind nmea_rmc_position_parser_core nrmc_checker u_nrmc_checker (.*);
